[rtl/wat_pkg.sv]
// Shared types and constants for the windowed adaptive threshold unit.
// Depends on nothing; every other file in rtl imports it.
`timescale 1ns / 1ps

package wat_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int LEVEL_W        = 32;
   localparam int LENGTH_W       = 6;
   localparam int CSR_INDEX_W    = 8;
   localparam int WINDOW_MAX_DEF = 32;

   // Bits of the rounded quotient; the change never reaches 2**15 LSBs.
   localparam int QUO_W = 15;

   // Reciprocal of ten for the trend step: floor(v * RECIP >> RECIP_SHIFT)
   // equals v / 10 for every v the step can produce.
   localparam int                 RECIP_SHIFT = 26;
   localparam logic [22:0]        RECIP_TEN   = 23'd6710887;

   localparam logic [CSR_INDEX_W-1:0] CSR_START  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWER  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH = 8'd3;

   localparam logic [LEVEL_W-1:0]  START_RESET  = 32'sd32768;
   localparam logic [LEVEL_W-1:0]  LOWER_RESET  = 32'sd0;
   localparam logic [LEVEL_W-1:0]  UPPER_RESET  = 32'sd65536;
   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 6'd32;

   typedef struct packed {
      logic store;
      logic rd_issue;
      logic rd_take;
      logic div_load;
      logic div_step;
      logic emit;
   } wat_cmd_type;

   typedef struct packed {
      logic idx_zero;
      logic div_last;
      logic out_free;
   } wat_status_type;

endpackage

[rtl/wat_ctrl.sv]
// Sequencer of the windowed adaptive threshold unit.
// Depends on wat_pkg; drives the datapath only through command and status.
`timescale 1ns / 1ps

module wat_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  wat_pkg::wat_status_type status,
   output wat_pkg::wat_cmd_type    cmd
);
   import wat_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RADDR,
      ST_RDATA,
      ST_DLOAD,
      ST_DSTEP,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.store = 1'b1;
               state_in  = ST_RADDR;
            end
         end
         ST_RADDR: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_RDATA;
         end
         ST_RDATA: begin
            cmd.rd_take = 1'b1;
            state_in    = status.idx_zero ? ST_DLOAD : ST_RADDR;
         end
         ST_DLOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DSTEP;
         end
         ST_DSTEP: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/wat_dpath.sv]
// Datapath: configuration registers, sample ring memory, window sums and
// trend accumulators, rounding divider, clamp and result register.
// Depends on wat_pkg; sequenced by wat_ctrl.
`timescale 1ns / 1ps

module wat_dpath #(
   parameter int WINDOW_MAX = wat_pkg::WINDOW_MAX_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [3*wat_pkg::SAMPLE_W-1:0]        req_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [wat_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [wat_pkg::LEVEL_W-1:0]           csr_data,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [wat_pkg::LEVEL_W+3*wat_pkg::SAMPLE_W-1:0] rsp_tdata,
   input  wat_pkg::wat_cmd_type                  cmd,
   output wat_pkg::wat_status_type               status
);
   import wat_pkg::*;

   localparam int SW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int FW   = $clog2(WINDOW_MAX + 1);
   localparam int CW   = (FW > LENGTH_W) ? FW : LENGTH_W;
   localparam int SUMW = SAMPLE_W + FW;
   localparam int NUMW = SUMW + 5;
   localparam int DVW  = FW + 8;
   localparam int DW   = FW + 22;
   localparam int QCW  = $clog2(QUO_W);
   localparam int EW   = 20;
   localparam int PW   = EW + 23;

   localparam logic [CW-1:0]   WMAX_C  = CW'(WINDOW_MAX);
   localparam logic [FW:0]     WMAX_S  = (FW + 1)'(WINDOW_MAX);
   localparam logic [FW-1:0]   WMAX_F  = FW'(WINDOW_MAX);

   // Configuration.
   logic signed [LEVEL_W-1:0] start_ff, lower_ff, upper_ff;
   logic [LENGTH_W-1:0]       length_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= START_RESET;
         lower_ff  <= LOWER_RESET;
         upper_ff  <= UPPER_RESET;
         length_ff <= LENGTH_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_START)  start_ff  <= csr_data;
         if (csr_index == CSR_LOWER)  lower_ff  <= csr_data;
         if (csr_index == CSR_UPPER)  upper_ff  <= csr_data;
         if (csr_index == CSR_LENGTH) length_ff <= csr_data[LENGTH_W-1:0];
      end
   end

   // Ring pointers.
   logic [FW-1:0] fill_ff, fill_in, n_ff;
   logic [SW-1:0] oldest_ff, oldest_in, idx_ff, wr_slot, rd_slot;
   logic [CW-1:0] len_eff, fill_inc;
   logic          full;

   function automatic logic [SW-1:0] slot_after(input logic [SW-1:0] base,
                                                input logic [FW-1:0] k);
      logic [FW:0] s;
      s = (FW + 1)'(base) + (FW + 1)'(k);
      if (s >= WMAX_S) s = s - WMAX_S;
      return s[SW-1:0];
   endfunction

   always_comb begin
      if (length_ff == '0)                     len_eff = CW'(1);
      else if (CW'(length_ff) > WMAX_C)        len_eff = WMAX_C;
      else                                     len_eff = CW'(length_ff);
      full      = (fill_ff == WMAX_F);
      fill_inc  = CW'(fill_ff) + CW'(1);
      wr_slot   = full ? oldest_ff : slot_after(oldest_ff, fill_ff);
      oldest_in = oldest_ff;
      fill_in   = fill_ff;
      if (full) begin
         oldest_in = slot_after(oldest_ff, FW'(1));
      end else if (fill_inc > len_eff) begin
         oldest_in = slot_after(oldest_ff, FW'(1));
      end else begin
         fill_in = fill_inc[FW-1:0];
      end
      rd_slot = slot_after(oldest_ff, FW'(idx_ff));
   end

   // Sample memory; entries are read only after they have been written.
   logic [3*SAMPLE_W-1:0] mem [WINDOW_MAX];
   logic [3*SAMPLE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.store) mem[wr_slot] <= req_tdata;
      if (cmd.rd_issue) rdata_ff <= mem[rd_slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         oldest_ff <= '0;
      end else if (cmd.store) begin
         fill_ff   <= fill_in;
         oldest_ff <= oldest_in;
      end
   end

   // Walk from the newest entry to the oldest.
   logic [SUMW-1:0]     se_ff, ss_ff, sr_ff;
   logic [SAMPLE_W-1:0] te_ff, ts_ff, tr_ff;
   logic                first_ff;

   function automatic logic [SAMPLE_W-1:0] ema_step(input logic [SAMPLE_W-1:0] x,
                                                    input logic [SAMPLE_W-1:0] e);
      logic [EW-1:0] v;
      logic [PW-1:0] p;
      v = EW'(x) * EW'(3) + EW'(e) * EW'(7) + EW'(5);
      p = PW'(v) * PW'(RECIP_TEN);
      return p[RECIP_SHIFT +: SAMPLE_W];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         n_ff     <= fill_in;
         idx_ff   <= SW'(fill_in - FW'(1));
         se_ff    <= '0;
         ss_ff    <= '0;
         sr_ff    <= '0;
         first_ff <= 1'b1;
      end else if (cmd.rd_take) begin
         se_ff    <= se_ff + SUMW'(rdata_ff[0 +: SAMPLE_W]);
         ss_ff    <= ss_ff + SUMW'(rdata_ff[SAMPLE_W +: SAMPLE_W]);
         sr_ff    <= sr_ff + SUMW'(rdata_ff[2*SAMPLE_W +: SAMPLE_W]);
         first_ff <= 1'b0;
         idx_ff   <= idx_ff - SW'(1);
         if (first_ff) begin
            te_ff <= rdata_ff[0 +: SAMPLE_W];
            ts_ff <= rdata_ff[SAMPLE_W +: SAMPLE_W];
            tr_ff <= rdata_ff[2*SAMPLE_W +: SAMPLE_W];
         end else begin
            te_ff <= ema_step(rdata_ff[0 +: SAMPLE_W], te_ff);
            ts_ff <= ema_step(rdata_ff[SAMPLE_W +: SAMPLE_W], ts_ff);
            tr_ff <= ema_step(rdata_ff[2*SAMPLE_W +: SAMPLE_W], tr_ff);
         end
      end
   end

   // Rounded change = (2|num| + den) / (2 den), den = 100 n, by restoring
   // division one quotient bit per cycle.
   logic signed [NUMW-1:0] num;
   logic [NUMW-1:0]        mag;
   logic [DVW-1:0]         den2;
   logic [DW-1:0]          rem_ff, dvs_ff;
   logic [QUO_W-1:0]       quo_ff;
   logic [QCW-1:0]         cnt_ff;
   logic                   neg_ff, ge;

   always_comb begin
      num = $signed(NUMW'({se_ff, 3'b000})) + $signed(NUMW'(se_ff) * NUMW'(0))
          + $signed(NUMW'(ss_ff) * NUMW'(6)) - $signed(NUMW'(sr_ff) * NUMW'(6))
          - $signed(NUMW'({n_ff, 18'b0}));
      mag  = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
      den2 = DVW'(n_ff) * DVW'(200);
      ge   = (rem_ff >= dvs_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= DW'({mag, 1'b0}) + DW'(n_ff) * DW'(100);
         dvs_ff <= DW'(den2) << (QUO_W - 1);
         quo_ff <= '0;
         cnt_ff <= QCW'(QUO_W - 1);
         neg_ff <= num[NUMW-1];
      end else if (cmd.div_step) begin
         if (ge) rem_ff <= rem_ff - dvs_ff;
         quo_ff <= {quo_ff[QUO_W-2:0], ge};
         dvs_ff <= dvs_ff >> 1;
         cnt_ff <= cnt_ff - QCW'(1);
      end
   end

   // Clamp and result register.
   logic signed [LEVEL_W-1:0] level_ff;
   logic                      started_ff;
   logic signed [LEVEL_W+1:0] sum, clamped;
   logic signed [LEVEL_W+1:0] chg;
   logic                      valid_ff;
   logic [LEVEL_W+3*SAMPLE_W-1:0] data_ff;

   always_comb begin
      chg     = neg_ff ? -$signed((LEVEL_W + 2)'(quo_ff)) : $signed((LEVEL_W + 2)'(quo_ff));
      sum     = (started_ff ? (LEVEL_W + 2)'(level_ff) : (LEVEL_W + 2)'(start_ff)) + chg;
      clamped = sum;
      if (clamped < (LEVEL_W + 2)'(lower_ff)) clamped = (LEVEL_W + 2)'(lower_ff);
      if (clamped > (LEVEL_W + 2)'(upper_ff)) clamped = (LEVEL_W + 2)'(upper_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= '0;
         started_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         if (cmd.emit) begin
            level_ff   <= clamped[LEVEL_W-1:0];
            started_ff <= 1'b1;
            valid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) data_ff <= {tr_ff, ts_ff, te_ff, clamped[LEVEL_W-1:0]};
   end

   assign rsp_tvalid      = valid_ff;
   assign rsp_tdata       = data_ff;
   assign status.idx_zero = (idx_ff == '0);
   assign status.div_last = (cnt_ff == '0);
   assign status.out_free = !valid_ff || rsp_tready;

endmodule

[rtl/windowed_adaptive_threshold_unit.sv]
// Top level of the windowed adaptive threshold unit.
// Usage: each req item carries one sample (efficiency, stability, error
// fraction, Q0.16). The unit appends it to a sliding window and returns one
// rsp item: the clamped Q16.16 threshold and one trend value per field.
// Registers are written over the csr channel (index 0 start threshold,
// 1 lower limit, 2 upper limit, 3 window length); the user must do so
// only while no item is in work, as the block itself does not enforce
// it. csr_ready is always high and unknown indexes are dropped.
// Each item is worked in order by a walk over the ring memory, with a
// read and an accumulate step per entry, then by the bit-serial divider
// and the clamp into the result register.
// A new item is taken once the previous one has reached the result
// register, even while that result still waits on rsp_tready; when the
// receiver stalls, the next result waits in the last step until the
// register frees up. Reset empties the window, restores register defaults
// and makes the next update start from the start threshold. It needs no
// clearing pass.
`timescale 1ns / 1ps

module windowed_adaptive_threshold_unit #(
   parameter int WINDOW_MAX = wat_pkg::WINDOW_MAX_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // efficiency[15:0], stability[31:16], error_fraction[47:32]
   input  logic [3*wat_pkg::SAMPLE_W-1:0]         req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // threshold[31:0], efficiency_trend[47:32], stability_trend[63:48],
   // error_trend[79:64]
   output logic [wat_pkg::LEVEL_W+3*wat_pkg::SAMPLE_W-1:0] rsp_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [wat_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [wat_pkg::LEVEL_W-1:0]            csr_data
);
   import wat_pkg::*;

   wat_cmd_type    cmd;
   wat_status_type status;

   wat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   wat_dpath #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

[bench/windowed_adaptive_threshold_unit_test.sv]
// Testbench for the windowed adaptive threshold unit: drives samples, predicts
// threshold and trends per item, and compares every response. Depends on wat_pkg.
`timescale 1ns / 1ps

module windowed_adaptive_threshold_unit_test;
   import wat_pkg::*;

   typedef struct packed {
      logic [15:0] err_tr;
      logic [15:0] stab_tr;
      logic [15:0] eff_tr;
      logic [31:0] level;
   } level_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [LEVEL_W-1:0] csr_data = '0;

   windowed_adaptive_threshold_unit uut (.*);

   // Predictor state.
   logic signed [31:0] start_lvl, low_lim, high_lim;
   logic [5:0] win_len;
   logic [15:0] ring_eff[32], ring_stab[32], ring_err[32];
   int unsigned fill, oldest;
   logic signed [31:0] level_now;
   bit level_started;

   level_result_t pending_results[$];
   int fail_count = 0;
   int result_count = 0;
   longint cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("[windowed_adaptive_threshold_unit] ERROR");
         $finish;
      end
   end

   function automatic logic [15:0] trend_step(logic [15:0] x, logic [15:0] ema);
      return 16'((3 * int'(x) + 7 * int'(ema) + 5) / 10);
   endfunction

   task automatic predict_sample(logic [15:0] e, logic [15:0] s, logic [15:0] r);
      int unsigned lim, n, slot;
      longint se, ss, sr, num, den, mag, chg, v;
      logic [15:0] te, ts, tr;
      level_result_t res;
      lim = (win_len == 0) ? 1 : (win_len > 32 ? 32 : win_len);
      se = 0; ss = 0; sr = 0;
      if (fill >= 32) begin
         fill = 32;
         ring_eff[oldest] = e; ring_stab[oldest] = s; ring_err[oldest] = r;
         oldest = (oldest + 1) % 32;
      end else begin
         slot = (oldest + fill) % 32;
         ring_eff[slot] = e; ring_stab[slot] = s; ring_err[slot] = r;
         fill++;
         if (fill > lim) begin
            oldest = (oldest + 1) % 32;
            fill--;
         end
      end
      n = fill;
      for (int i = 0; i < n; i++) begin
         slot = (oldest + i) % 32;
         se += ring_eff[slot]; ss += ring_stab[slot]; sr += ring_err[slot];
      end
      num = 8 * se + 6 * ss - 6 * sr - 4 * 65536 * longint'(n);
      den = 100 * longint'(n);
      mag = num < 0 ? -num : num;
      mag = (2 * mag + den) / (2 * den);
      chg = num < 0 ? -mag : mag;
      v = (level_started ? longint'(level_now) : longint'(start_lvl)) + chg;
      if (v < longint'(low_lim)) v = low_lim;
      if (v > longint'(high_lim)) v = high_lim;
      level_now = v[31:0];
      level_started = 1'b1;
      slot = (oldest + n - 1) % 32;
      te = ring_eff[slot]; ts = ring_stab[slot]; tr = ring_err[slot];
      for (int i = n - 1; i > 0; i--) begin
         slot = (oldest + i - 1) % 32;
         te = trend_step(ring_eff[slot], te);
         ts = trend_step(ring_stab[slot], ts);
         tr = trend_step(ring_err[slot], tr);
      end
      res.level = level_now; res.eff_tr = te; res.stab_tr = ts; res.err_tr = tr;
      pending_results.insert(pending_results.size(), res);
   endtask

   // Response side: random stalls on the falling edge, checks on the rising edge.
   always @(negedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      level_result_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         result_count++;
         if (pending_results.size() == 0) begin
            $error("unexpected result %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.level !== want.level) begin
               $error("threshold: expected %0d got %0d", $signed(want.level),
                      $signed(got.level));
               fail_count++;
            end
            if (got.eff_tr !== want.eff_tr) begin
               $error("efficiency_trend: expected %0d got %0d", want.eff_tr, got.eff_tr);
               fail_count++;
            end
            if (got.stab_tr !== want.stab_tr) begin
               $error("stability_trend: expected %0d got %0d", want.stab_tr, got.stab_tr);
               fail_count++;
            end
            if (got.err_tr !== want.err_tr) begin
               $error("error_trend: expected %0d got %0d", want.err_tr, got.err_tr);
               fail_count++;
            end
         end
      end
   end

   // Inputs are set with blocking writes at the falling edge, so back-to-back
   // items may drop and raise tvalid in the same step without a conflict.
   task automatic send_sample(logic [15:0] e, logic [15:0] s, logic [15:0] r);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {r, s, e};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_sample(e, s, r);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_START:  start_lvl = val;
         CSR_LOWER:  low_lim = val;
         CSR_UPPER:  high_lim = val;
         CSR_LENGTH: win_len = val[5:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [15:0] rand_field();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   task automatic test_directed();
      // Start threshold is used only for the first update; later writes are ignored.
      write_reg(CSR_START, 32'sd100000);
      write_reg(CSR_LOWER, -32'sd200000);
      write_reg(CSR_UPPER, 32'sd300000);
      write_reg(CSR_LENGTH, 32'd1);
      send_sample(16'hFFFF, 16'hFFFF, 16'h0000);
      send_sample(16'h0000, 16'h0000, 16'hFFFF);
      wait_drained();
      write_reg(CSR_START, 32'sd7);
      write_reg(CSR_LENGTH, 32'd0);
      send_sample(16'h8000, 16'h5555, 16'hAAAA);
      wait_drained();
      write_reg(CSR_LENGTH, 32'd63);
      for (int i = 0; i < 6; i++) send_sample(16'hFFFF, 16'h0000, 16'hFFFF);
      wait_drained();
      // A length below the fill does not shrink the window; each sample replaces the oldest entry.
      write_reg(CSR_LENGTH, 32'd2);
      for (int i = 0; i < 5; i++) send_sample(16'h0001, 16'hFFFE, 16'h1234);
      wait_drained();
      // Lower limit above upper: the upper limit wins.
      write_reg(CSR_LOWER, 32'sd50000);
      write_reg(CSR_UPPER, 32'sd40000);
      send_sample(16'hFFFF, 16'hFFFF, 16'h0000);
      wait_drained();
      // Extreme limits and two unknown register indexes.
      write_reg(CSR_LOWER, 32'h8000_0000);
      write_reg(CSR_UPPER, 32'h7FFF_FFFF);
      write_reg(8'hFF, 32'hDEAD_BEEF);
      write_reg(8'd4, 32'h1);
      for (int i = 0; i < 4; i++) send_sample(16'h0000, 16'h0000, 16'hFFFF);
      wait_drained();
   endtask

   task automatic test_random(int count, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            // Hold the sender until every expected result has come back.
            while (pending_results.size() != 0) @(negedge clock);
         end
         send_sample(rand_field(), rand_field(), rand_field());
      end
      wait_drained();
   endtask

   task automatic test_settings();
      logic [5:0] lens[6] = '{6'd1, 6'd2, 6'd5, 6'd32, 6'd40, 6'd16};
      foreach (lens[k]) begin
         write_reg(CSR_LENGTH, 32'(lens[k]));
         write_reg(CSR_LOWER, -$signed(32'($urandom_range(100000))));
         write_reg(CSR_UPPER, $urandom_range(200000));
         write_reg(CSR_START, $urandom);
         test_random(55, k % 2 ? 53 : 0, k % 3 == 1 ? 53 : 0);
      end
   endtask

   initial begin
      start_lvl = 32768; low_lim = 0; high_lim = 65536; win_len = 32;
      fill = 0; oldest = 0; level_now = 0; level_started = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random(250, 0, 0);
      test_random(250, 53, 0);
      test_random(250, 0, 53);
      test_random(250, 10, 10);
      test_settings();
      $display("Covered directed limit and window cases plus random samples over");
      $display("several window lengths and limits; %0d results checked.", result_count);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("[windowed_adaptive_threshold_unit] OK");
      else
         $display("[windowed_adaptive_threshold_unit] ERROR");
      $finish;
   end
endmodule
